@@ design/lsh_pkg.sv @@
// ----------------------------------------------------------------------------
// lsh_pkg: shared types and codes for the link setup handshake
// Input operation codes, register indexes, recognizer and link states,
// and the structs that run between the submodules.
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned FrameLen  = 5;

  // Input operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_ROLE    = 3'd0;
  localparam logic [2:0] REG_FLAG    = 3'd1;
  localparam logic [2:0] REG_ADDR    = 3'd2;
  localparam logic [2:0] REG_SETCTRL = 3'd3;
  localparam logic [2:0] REG_UACTRL  = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;
  localparam logic [2:0] REG_RETRIES = 3'd6;

  // Role codes
  localparam logic ROLE_INITIATOR = 1'b0;

  // Frame byte positions
  localparam logic [2:0] POS_FLAG_OPEN  = 3'd0;
  localparam logic [2:0] POS_ADDR       = 3'd1;
  localparam logic [2:0] POS_CTRL       = 3'd2;
  localparam logic [2:0] POS_BCC        = 3'd3;
  localparam logic [2:0] POS_FLAG_CLOSE = 3'd4;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_FLAG  = 3'd1,
    PH_ADDR  = 3'd2,
    PH_CTRL  = 3'd3,
    PH_BCC   = 3'd4
  } match_phase_t;

  typedef enum logic [1:0] {
    LINK_IDLE = 2'd0,
    LINK_WAIT = 2'd1,
    LINK_UP   = 2'd2,
    LINK_FAIL = 2'd3
  } link_phase_t;

  typedef struct packed {
    logic       role;
    logic [7:0] flag_byte;
    logic [7:0] addr_byte;
    logic [7:0] set_ctrl;
    logic [7:0] ua_ctrl;
    logic [7:0] timeout_ticks;
    logic [3:0] max_retries;
  } cfg_t;

  typedef struct packed {
    logic        frame;
    logic [7:0]  ctrl;
    link_phase_t status;
  } emit_req_t;

endpackage

@@ design/lsh_cfg.sv @@
// ----------------------------------------------------------------------------
// lsh_cfg: configuration register file
// APB-style write and read of the seven link setup registers.
// ----------------------------------------------------------------------------
module lsh_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsh_pkg::AddrWidth-1:0]   paddr,
  input  logic [lsh_pkg::DataWidth-1:0]   pwdata,
  output logic [lsh_pkg::DataWidth-1:0]   prdata,
  output logic                            pready,
  output lsh_pkg::cfg_t                   cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:2];
  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.role          <= 1'b0;
      cfg.flag_byte     <= 8'd126;
      cfg.addr_byte     <= 8'd3;
      cfg.set_ctrl      <= 8'd3;
      cfg.ua_ctrl       <= 8'd7;
      cfg.timeout_ticks <= 8'd3;
      cfg.max_retries   <= 4'd3;
    end else if (wr_en) begin
      case (reg_index)
        lsh_pkg::REG_ROLE:    cfg.role          <= pwdata[0];
        lsh_pkg::REG_FLAG:    cfg.flag_byte     <= pwdata[7:0];
        lsh_pkg::REG_ADDR:    cfg.addr_byte     <= pwdata[7:0];
        lsh_pkg::REG_SETCTRL: cfg.set_ctrl      <= pwdata[7:0];
        lsh_pkg::REG_UACTRL:  cfg.ua_ctrl       <= pwdata[7:0];
        lsh_pkg::REG_TIMEOUT: cfg.timeout_ticks <= pwdata[7:0];
        lsh_pkg::REG_RETRIES: cfg.max_retries   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_index)
      lsh_pkg::REG_ROLE:    prdata = {31'd0, cfg.role};
      lsh_pkg::REG_FLAG:    prdata = {24'd0, cfg.flag_byte};
      lsh_pkg::REG_ADDR:    prdata = {24'd0, cfg.addr_byte};
      lsh_pkg::REG_SETCTRL: prdata = {24'd0, cfg.set_ctrl};
      lsh_pkg::REG_UACTRL:  prdata = {24'd0, cfg.ua_ctrl};
      lsh_pkg::REG_TIMEOUT: prdata = {24'd0, cfg.timeout_ticks};
      lsh_pkg::REG_RETRIES: prdata = {28'd0, cfg.max_retries};
      default:              prdata = '0;
    endcase
  end

endmodule

@@ design/lsh_proto.sv @@
// ----------------------------------------------------------------------------
// lsh_proto: handshake protocol state
// Frame recognizer, link phase, retry and tick counters; updated once per
// accepted item, and the frame request that the item causes.
// ----------------------------------------------------------------------------
module lsh_proto (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         op,
  input  logic [7:0]         rx_byte,
  input  lsh_pkg::cfg_t      cfg,
  output lsh_pkg::emit_req_t req
);

  lsh_pkg::match_phase_t match_phase, match_phase_next, phase_rx;
  lsh_pkg::link_phase_t  link_phase, link_phase_next;
  logic [3:0]            retries_used, retries_used_next;
  logic [7:0]            ticks_waited, ticks_waited_next;

  logic [7:0] ctrl_sel;
  logic [7:0] bcc;
  logic       is_flag;
  logic       frame_done;
  logic [7:0] ticks_inc;
  logic       expired;
  logic       can_retry;
  logic       waiting;
  logic       initiator;

  assign initiator = (cfg.role == lsh_pkg::ROLE_INITIATOR);
  assign waiting   = (link_phase == lsh_pkg::LINK_WAIT);
  assign ctrl_sel  = initiator ? cfg.ua_ctrl : cfg.set_ctrl;
  assign bcc       = cfg.addr_byte ^ ctrl_sel;
  assign is_flag   = (rx_byte == cfg.flag_byte);
  assign ticks_inc = ticks_waited + 8'd1;
  assign expired   = (ticks_inc >= cfg.timeout_ticks);
  assign can_retry = (retries_used < cfg.max_retries);

  // Recognizer step; a stray flag falls back to the flag-seen phase
  always_comb begin
    phase_rx   = lsh_pkg::PH_START;
    frame_done = 1'b0;
    case (match_phase)
      lsh_pkg::PH_START: begin
        phase_rx = is_flag ? lsh_pkg::PH_FLAG : lsh_pkg::PH_START;
      end
      lsh_pkg::PH_FLAG: begin
        if (rx_byte == cfg.addr_byte) phase_rx = lsh_pkg::PH_ADDR;
        else phase_rx = is_flag ? lsh_pkg::PH_FLAG : lsh_pkg::PH_START;
      end
      lsh_pkg::PH_ADDR: begin
        if (rx_byte == ctrl_sel) phase_rx = lsh_pkg::PH_CTRL;
        else phase_rx = is_flag ? lsh_pkg::PH_FLAG : lsh_pkg::PH_START;
      end
      lsh_pkg::PH_CTRL: begin
        if (rx_byte == bcc) phase_rx = lsh_pkg::PH_BCC;
        else phase_rx = is_flag ? lsh_pkg::PH_FLAG : lsh_pkg::PH_START;
      end
      lsh_pkg::PH_BCC: begin
        phase_rx   = lsh_pkg::PH_START;
        frame_done = is_flag;
      end
      default: begin
        phase_rx = lsh_pkg::PH_START;
      end
    endcase
  end

  // Next state
  always_comb begin
    match_phase_next  = match_phase;
    link_phase_next   = link_phase;
    retries_used_next = retries_used;
    ticks_waited_next = ticks_waited;
    case (op)
      lsh_pkg::OP_START: begin
        match_phase_next  = lsh_pkg::PH_START;
        link_phase_next   = lsh_pkg::LINK_WAIT;
        retries_used_next = 4'd0;
        ticks_waited_next = 8'd0;
      end
      lsh_pkg::OP_BYTE: begin
        if (waiting) begin
          match_phase_next = phase_rx;
          if (frame_done) begin
            link_phase_next   = lsh_pkg::LINK_UP;
            ticks_waited_next = 8'd0;
          end
        end
      end
      lsh_pkg::OP_TICK: begin
        if (waiting && initiator) begin
          ticks_waited_next = ticks_inc;
          if (expired) begin
            ticks_waited_next = 8'd0;
            if (can_retry) retries_used_next = retries_used + 4'd1;
            else link_phase_next = lsh_pkg::LINK_FAIL;
          end
        end
      end
      default: ;
    endcase
  end

  // Frame request for the result stage
  always_comb begin
    req.frame  = 1'b0;
    req.ctrl   = cfg.set_ctrl;
    req.status = link_phase_next;
    case (op)
      lsh_pkg::OP_START: begin
        req.frame = initiator;
      end
      lsh_pkg::OP_BYTE: begin
        req.frame = waiting && frame_done && !initiator;
        req.ctrl  = cfg.ua_ctrl;
      end
      lsh_pkg::OP_TICK: begin
        req.frame = waiting && initiator && expired && can_retry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_phase  <= lsh_pkg::PH_START;
      link_phase   <= lsh_pkg::LINK_IDLE;
      retries_used <= 4'd0;
      ticks_waited <= 8'd0;
    end else if (accept) begin
      match_phase  <= match_phase_next;
      link_phase   <= link_phase_next;
      retries_used <= retries_used_next;
      ticks_waited <= ticks_waited_next;
    end
  end

  // Start always opens a fresh exchange
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && op == lsh_pkg::OP_START |=>
      link_phase == lsh_pkg::LINK_WAIT && retries_used == 4'd0 &&
      ticks_waited == 8'd0 && match_phase == lsh_pkg::PH_START)
    else $error("start did not reset the exchange");

  // A completed frame leaves the recognizer at start with the link up
  a_frame_up: assert property (@(posedge clk) disable iff (rst)
    accept && op == lsh_pkg::OP_BYTE && waiting && frame_done |=>
      link_phase == lsh_pkg::LINK_UP && match_phase == lsh_pkg::PH_START)
    else $error("recognized frame did not bring the link up");

endmodule

@@ design/lsh_emit.sv @@
// ----------------------------------------------------------------------------
// lsh_emit: result sequencer
// Holds the result of the last item and steps through the five frame
// bytes, one per taken result.
// ----------------------------------------------------------------------------
module lsh_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  lsh_pkg::emit_req_t req,
  input  lsh_pkg::cfg_t      cfg,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               busy,
  output logic [7:0]         tx_byte,
  output logic               tx_valid,
  output logic               last,
  output logic [1:0]         link_status
);

  logic [2:0]           pos;
  logic                 frame;
  logic [7:0]           ctrl;
  lsh_pkg::link_phase_t status;
  logic                 take;

  assign take        = out_valid & ~out_stall;
  assign tx_valid    = frame;
  assign last        = ~frame | (pos == lsh_pkg::POS_FLAG_CLOSE);
  assign link_status = status;
  // Busy while a result is waiting, unless it is the final one and is taken
  assign busy        = out_valid & ~(take & last);

  always_comb begin
    tx_byte = 8'd0;
    if (frame) begin
      case (pos)
        lsh_pkg::POS_FLAG_OPEN:  tx_byte = cfg.flag_byte;
        lsh_pkg::POS_ADDR:       tx_byte = cfg.addr_byte;
        lsh_pkg::POS_CTRL:       tx_byte = ctrl;
        lsh_pkg::POS_BCC:        tx_byte = cfg.addr_byte ^ ctrl;
        lsh_pkg::POS_FLAG_CLOSE: tx_byte = cfg.flag_byte;
        default:                 tx_byte = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= lsh_pkg::POS_FLAG_OPEN;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= lsh_pkg::POS_FLAG_OPEN;
    end else if (take) begin
      if (last) out_valid <= 1'b0;
      else pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame  <= req.frame;
      ctrl   <= req.ctrl;
      status <= req.status;
    end
  end

  a_load_first: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && pos == lsh_pkg::POS_FLAG_OPEN)
    else $error("loaded item does not start at its first result");

  a_step: assert property (@(posedge clk) disable iff (rst)
    take && !last && !load |=> out_valid && pos == $past(pos) + 3'd1)
    else $error("frame byte position did not advance");

endmodule

@@ design/link_setup_handshake_unit.sv @@
// ----------------------------------------------------------------------------
// link_setup_handshake_unit: SET/UA serial link setup handshake
// Top level joining the register file, protocol state and result sequencer.
// ----------------------------------------------------------------------------
// Each input item (start, received byte or tick) updates the protocol state
// in the cycle it is accepted and loads one result register. An item that
// sends a frame yields five results (flag, address, control, address XOR
// control, flag) with last on the fifth; every other item yields a single
// result with tx_valid low and last high. link_status on every result is the
// link state after the item. The result sequencer hands out one frame byte
// per cycle while out_stall is low, and the next item is accepted in the
// cycle the final result of the previous one is taken. Registers are
// written over the APB-style port at byte address 4*i; the user must write
// them only while no item is in flight, and the block does not enforce it.
// ----------------------------------------------------------------------------
module link_setup_handshake_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Input item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      op,
  input  logic [7:0]                      rx_byte,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      tx_byte,
  output logic                            tx_valid,
  output logic                            last,
  output logic [1:0]                      link_status,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsh_pkg::AddrWidth-1:0]   paddr,
  input  logic [lsh_pkg::DataWidth-1:0]   pwdata,
  output logic [lsh_pkg::DataWidth-1:0]   prdata,
  output logic                            pready
);

  lsh_pkg::cfg_t      cfg;
  lsh_pkg::emit_req_t req;
  logic               in_accept;
  logic               busy;

  // Take a new item once the result register is empty or its final
  // result leaves in this cycle
  assign in_stall  = busy;
  assign in_accept = in_valid & ~in_stall;

  lsh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance recognizer, link phase and counters on each accepted item
  lsh_proto u_proto (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .op      (op),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .req     (req)
  );

  // Hold the item's results and release them one per taken cycle
  lsh_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (in_accept),
    .req         (req),
    .cfg         (cfg),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .busy        (busy),
    .tx_byte     (tx_byte),
    .tx_valid    (tx_valid),
    .last        (last),
    .link_status (link_status)
  );

endmodule
